// File: rtl/lkv_pkg.sv
package lkv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes carried on req_op
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;   // latch the key compare result
      logic upd_en;   // perform the recency shift this cycle
      logic hit;      // the access found its key
      logic evict;    // a missing put into a full cache drops the least recent entry
   } cell_ctl_type;

endpackage

// File: rtl/lru_key_value_cache.sv
// A request passes the key compare state in every cell, then the shift state of
// the recency chain, which holds while the result register is full. New requests
// are taken in idle or as the shift state finishes, never during the compare.
// Reset (synchronous, active high) empties the cache at once by clearing every
// cell's valid bit and sets the capacity register to 16.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic signed [lkv_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lkv_pkg::VAL_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic signed [lkv_pkg::VAL_W-1:0]   rsp_read_value,
   output logic                               rsp_evicted,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]          csr_capacity_in_use
);
   import lkv_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_eff;

   logic             req_op_ff;
   logic [KEY_W-1:0] req_key_ff;
   logic [VAL_W-1:0] req_value_ff;

   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_read_value_ff;
   logic             rsp_evicted_ff;

   logic             req_xfer;
   logic             out_free;
   logic             finish;
   logic             any_hit;
   logic             full;
   logic [VAL_W-1:0] hit_value;
   logic [VAL_W-1:0] head_value;
   cell_ctl_type     ctl;

   logic [KEY_W-1:0] chain_key   [ENTRIES+1];
   logic [VAL_W-1:0] chain_value [ENTRIES+1];
   logic [ENTRIES:0] chain_valid;
   logic [ENTRIES:0] chain_found;
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] full_vec;

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_UPDATE) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // clamp the capacity into 1..ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > ENTRIES) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (finish) begin
               state_in = req_xfer ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   // hold the request for the compare and shift cycles
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_op_ff    <= req_op;
         req_key_ff   <= $unsigned(req_key);
         req_value_ff <= $unsigned(req_value);
      end
   end

   // gather hit, stored value and fullness across the cells
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_value = hit_value | chain_value[i+1];
         end
      end
   end

   assign any_hit = |match_vec;
   assign full    = |full_vec;

   assign ctl.cmp_en = (state_ff == ST_LOOKUP);
   assign ctl.upd_en = finish && ((req_op_ff == OP_PUT) || any_hit);
   assign ctl.hit    = any_hit;
   assign ctl.evict  = (req_op_ff == OP_PUT) && !any_hit && full;

   // head of the chain: the accessed pair enters as most recent
   assign head_value     = (req_op_ff == OP_PUT) ? req_value_ff : hit_value;
   assign chain_key[0]   = req_key_ff;
   assign chain_value[0] = head_value;
   assign chain_valid[0] = 1'b1;
   assign chain_found[0] = 1'b0;

   // recency chain, cell 0 most recent
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cmp_key    (req_key_ff),
         .prev_key   (chain_key[i]),
         .prev_value (chain_value[i]),
         .prev_valid (chain_valid[i]),
         .found_in   (chain_found[i]),
         .key        (chain_key[i+1]),
         .value      (chain_value[i+1]),
         .valid      (chain_valid[i+1]),
         .match      (match_vec[i]),
         .found_out  (chain_found[i+1])
      );
      assign valid_vec[i] = chain_valid[i+1];
      assign full_vec[i]  = chain_valid[i+1] && (cap_eff == CNT_W'(i + 1));
   end

   // result register, parts the response side from the cell chain
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff        <= any_hit;
         rsp_read_value_ff <= (req_op_ff == OP_GET && any_hit) ? hit_value : '0;
         rsp_evicted_ff    <= ctl.evict;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = $signed(rsp_read_value_ff);
   assign rsp_evicted    = rsp_evicted_ff;

   // valid entries form one run from the most recent cell
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("valid cells do not form a contiguous run");

   // a key lives in at most one cell
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key matched in more than one cell");

   // a result appears only out of the shift cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised outside the shift cycle");

   // eviction never reported together with a hit
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_evicted_ff && rsp_hit_ff))
      else $error("eviction reported together with a hit");

   // no new request during the compare cycle
   a_no_take_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> !req_ready)
      else $error("request taken during compare");

endmodule

// File: rtl/lkv_cell.sv
module lkv_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lkv_pkg::cell_ctl_type       ctl,
   input  logic [lkv_pkg::KEY_W-1:0]   cmp_key,
   input  logic [lkv_pkg::KEY_W-1:0]   prev_key,
   input  logic [lkv_pkg::VAL_W-1:0]   prev_value,
   input  logic                        prev_valid,
   input  logic                        found_in,
   output logic [lkv_pkg::KEY_W-1:0]   key,
   output logic [lkv_pkg::VAL_W-1:0]   value,
   output logic                        valid,
   output logic                        match,
   output logic                        found_out
);
   import lkv_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic             valid_ff;
   logic             match_ff;
   logic             match_in;
   logic             shift_in;

   // compare the stored key against the broadcast key
   assign match_in = valid_ff && (key_ff == cmp_key);

   // take the neighbor's entry when the recency shift reaches this cell
   always_comb begin
      if (!ctl.upd_en) begin
         shift_in = 1'b0;
      end else if (ctl.hit) begin
         shift_in = !found_in;
      end else if (ctl.evict) begin
         shift_in = valid_ff;
      end else begin
         shift_in = prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.cmp_en) begin
            match_ff <= match_in;
         end
         if (shift_in) begin
            valid_ff <= prev_valid;
         end
      end
   end

   // entry payload, no reset
   always_ff @(posedge clock) begin
      if (shift_in) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

   assign key       = key_ff;
   assign value     = value_ff;
   assign valid     = valid_ff;
   assign match     = match_ff;
   assign found_out = found_in | match_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lkv_pkg::*;

   localparam int DEPTH          = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL_SIZE      = 32;
   localparam int MAX_PRINTS     = 20;

   // one access outcome as the cache should report it
   typedef struct {
      logic             op;
      logic [KEY_W-1:0] key;
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
   } access_result_type;

   // Shadow LRU chain: slot 0 is most recent, valid slots run from 0 up
   class lru_scoreboard_type;
      logic [KEY_W-1:0]  slot_key [DEPTH];
      logic [VAL_W-1:0]  slot_value [DEPTH];
      int                fill;
      logic [CAP_W-1:0]  capacity;
      access_result_type awaited_results [$];
      int                mismatches;
      int                n_access;
      int                n_get;
      int                n_put;
      int                n_hit;
      int                n_evict;

      function new();
         fill       = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
         n_access   = 0;
         n_get      = 0;
         n_put      = 0;
         n_hit      = 0;
         n_evict    = 0;
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // shift slots 0..pos-1 down one place and put the pair at the front
      function void promote(int pos, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
         for (int j = pos; j > 0; j--) begin
            slot_key[j]   = slot_key[j-1];
            slot_value[j] = slot_value[j-1];
         end
         slot_key[0]   = key;
         slot_value[0] = value;
      endfunction

      // predict the outcome of one accepted access and update the chain
      function void note_access(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
         access_result_type res;
         int                pos;
         int                limit;
         bit                found;

         pos   = 0;
         found = 0;
         limit = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
         for (int i = 0; i < fill; i++) begin
            if (!found && slot_key[i] == key) begin
               found = 1;
               pos   = i;
            end
         end

         res.op         = op;
         res.key        = key;
         res.hit        = found;
         res.read_value = '0;
         res.evicted    = 1'b0;

         if (op == OP_GET) begin
            n_get++;
            if (found) begin
               res.read_value = slot_value[pos];
               promote(pos, key, slot_value[pos]);
            end
         end else if (found) begin
            n_put++;
            promote(pos, key, value);
         end else begin
            n_put++;
            // a full cache drops only its least recent entry
            if (fill >= limit) begin
               fill--;
               res.evicted = 1'b1;
               n_evict++;
            end
            promote(fill, key, value);
            fill++;
         end

         if (found)
            n_hit++;
         n_access++;
         awaited_results.push_back(res);
      endfunction

      // compare one response transfer with the oldest prediction
      function void check_result(logic hit, logic [VAL_W-1:0] read_value, logic evicted);
         access_result_type want;

         if (awaited_results.size() == 0) begin
            report_mismatch("response with no access outstanding");
            return;
         end
         want = awaited_results.pop_front();
         if (hit !== want.hit)
            report_mismatch($sformatf("op %0b key %h: hit %b, expected %b",
                                      want.op, want.key, hit, want.hit));
         if (read_value !== want.read_value)
            report_mismatch($sformatf("op %0b key %h: read_value %h, expected %h",
                                      want.op, want.key, read_value, want.read_value));
         if (evicted !== want.evicted)
            report_mismatch($sformatf("op %0b key %h: evicted %b, expected %b",
                                      want.op, want.key, evicted, want.evicted));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = OP_GET;
   logic signed [KEY_W-1:0]   req_key = '0;
   logic signed [VAL_W-1:0]   req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic signed [VAL_W-1:0]   rsp_read_value;
   logic                      rsp_evicted;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CAP_W-1:0]          csr_capacity_in_use = '0;

   lru_scoreboard_type cache_sb;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 quiet_cycles = 0;
   logic [CAP_W-1:0]   cap_setting = CAP_RESET;
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];

   lru_key_value_cache #(
      .ENTRIES(DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_key             (req_key),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .rsp_evicted         (rsp_evicted),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   always #5 clock = ~clock;

   // stall the response channel at random
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watch every transfer; end the run if the block goes quiet too long
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            cache_sb.check_result(rsp_hit, rsp_read_value, rsp_evicted);
         if (req_valid && req_ready)
            cache_sb.note_access(req_op, req_key, req_value);
         if (csr_valid && csr_ready)
            cache_sb.set_capacity(csr_capacity_in_use);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, cache_sb.pending());
            $display("** lru_key_value_cache: FAILED **");
            $finish;
         end
      end
   end

   // present one access, idling first at random, and hold it until transfer
   task automatic send_access(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for every outstanding response
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cache_sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the capacity register once the cache has gone idle
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cap_setting = value;
   endtask

   initial begin
      logic [CAP_W-1:0] phase_cap [6];
      int               phase_items [6];
      logic [KEY_W-1:0] rand_key;
      logic [VAL_W-1:0] rand_value;
      int               eff_cap;
      int               span;

      cache_sb = new();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom();

      phase_cap   = '{5'd16, 5'd1, 5'd31, 5'($urandom_range(2, 15)), 5'd16,
                      5'($urandom_range(0, 31))};
      phase_items = '{235, 200, 250, 250, 250, 250};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 35;
      rsp_stall_pct = 51;

      // fill and reorder the chain with the extreme keys at reset capacity
      send_access(OP_GET, key_pool[2], 32'h0000_0000);
      send_access(OP_PUT, key_pool[0], 32'h7FFF_FFFF);
      send_access(OP_PUT, key_pool[1], 32'h8000_0000);
      send_access(OP_PUT, key_pool[2], 32'h0000_0000);
      send_access(OP_PUT, key_pool[3], 32'hFFFF_FFFF);
      send_access(OP_GET, key_pool[0], 32'h5555_5555);
      send_access(OP_PUT, key_pool[1], 32'h1234_5678);
      send_access(OP_GET, key_pool[1], 32'hAAAA_AAAA);
      // a missing get ignores its value field
      send_access(OP_GET, key_pool[4], 32'hFFFF_FFFF);

      // capacity below occupancy: each missing put drops one entry only
      write_capacity(5'd2);
      send_access(OP_PUT, key_pool[4], $urandom());
      send_access(OP_GET, key_pool[2], $urandom());

      // capacity zero behaves as one
      write_capacity(5'd0);
      send_access(OP_PUT, key_pool[5], $urandom());
      send_access(OP_PUT, key_pool[5], $urandom());
      send_access(OP_GET, key_pool[5], $urandom());
      send_access(OP_GET, key_pool[3], $urandom());

      // random traffic over a key pool a little larger than the capacity
      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            send_idle_pct = 51;
            rsp_stall_pct = 35;
         end
         if (p == 4) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         write_capacity(phase_cap[p]);
         eff_cap = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
         span    = (eff_cap + 6 > POOL_SIZE) ? POOL_SIZE : eff_cap + 6;
         repeat (phase_items[p]) begin
            if ($urandom_range(99) < 8)
               rand_key = $urandom();
            else
               rand_key = key_pool[$urandom_range(0, span - 1)];
            if ($urandom_range(9) == 0)
               rand_value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
               rand_value = $urandom();
            send_access($urandom_range(1) ? OP_PUT : OP_GET, rand_key, rand_value);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (cache_sb.pending() != 0)
         cache_sb.report_mismatch($sformatf("%0d responses never arrived",
                                            cache_sb.pending()));

      $display("Covered %0d accesses (%0d gets, %0d puts): %0d hits, %0d evictions,",
               cache_sb.n_access, cache_sb.n_get, cache_sb.n_put, cache_sb.n_hit,
               cache_sb.n_evict);
      $display("capacities 0, 1, 2, 16, 31 and random, under sender and receiver %s%0d",
               "stalls; mismatches ", cache_sb.mismatches);
      if (cache_sb.mismatches == 0)
         $display("** lru_key_value_cache: PASSED **");
      else
         $display("** lru_key_value_cache: FAILED **");
      $finish;
   end

endmodule
